// File: rtl/crt_pkg.sv
`timescale 1ns / 1ps
// Shared widths and status codes for the incremental CRT solver.
// No dependencies; imported by crt_incremental_solver, crt_solution_checker and the testbench.
package crt_pkg;

    localparam int SOL_W      = 64;
    localparam int MOD_W      = 32;
    localparam int ST_W       = 2;
    localparam int S_TDATA_W  = 2 * MOD_W;
    localparam int M_TDATA_W  = ((2 * SOL_W + ST_W + 7) / 8) * 8;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_COPRIME = 2'd1,
        ST_OVERFLOW    = 2'd2
    } t_status;

endpackage

// File: rtl/crt_incremental_solver.sv
`timescale 1ns / 1ps
// Incremental Chinese-remainder solver with a shared shift-subtract unit.
// Depends on crt_pkg for widths and status codes.

// Each input word is one congruence; it is solved while o_s_tready stays low,
// and one result word follows. A start word only reduces its residue with the
// shift-subtract divider. A merge word runs the divider to reduce the residue,
// then once for every extended Euclid step; a shift-add multiply forms the new
// modulus, the divider reduces the residue again, and a modular multiply and a
// second shift-add multiply form the solution. A merge word that arrives while
// an error is held, or any word with a zero modulus, goes straight to the output
// state. The next word is accepted while the last result still waits.
module crt_incremental_solver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // residue [31:0], modulus [63:32]
    input  logic [crt_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // start_system [0]
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // solution [63:0], combined_modulus [127:64], status [129:128], zeros above
    output logic [crt_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import crt_pkg::*;

    localparam int T_W = SOL_W + 4;
    localparam int P_W = SOL_W + MOD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SUB, S_DDONE, S_ECHK, S_FIX1, S_FIX2,
        S_MUL, S_MCHK, S_MMA, S_MMB, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_RED, PH_EUC, PH_RBIG, PH_PROD, PH_SOL
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    t_status             r_st;
    logic [SOL_W-1:0]    r_sol;
    logic [SOL_W-1:0]    r_modr;
    logic                r_start;
    logic [MOD_W-1:0]    r_res;
    logic [MOD_W-1:0]    r_m;
    logic [SOL_W-1:0]    r_ra;
    logic [SOL_W-1:0]    r_rb;
    logic [SOL_W:0]      r_d;
    logic signed [T_W-1:0] r_ta;
    logic signed [T_W-1:0] r_tb;
    logic signed [T_W-1:0] r_td;
    logic [5:0]          r_cnt;
    logic [SOL_W-1:0]    r_inv;
    logic [SOL_W-1:0]    r_x;
    logic [SOL_W-1:0]    r_acc;
    logic [P_W-1:0]      r_macc;
    logic [SOL_W-1:0]    r_mc;
    logic [MOD_W-1:0]    r_mm;
    logic [SOL_W-1:0]    r_prod;
    logic                r_ovalid;
    logic [SOL_W-1:0]    r_out_sol;
    logic [SOL_W-1:0]    r_out_mod;
    t_status             r_out_st;

    logic                accept;
    logic [MOD_W-1:0]    in_res;
    logic [MOD_W-1:0]    in_m;
    logic                shift_ok;
    logic                sub_ge;
    logic [SOL_W-1:0]    am_b;
    logic [SOL_W-1:0]    am_gap;
    logic [SOL_W-1:0]    am_res;
    logic [SOL_W-1:0]    fix_inv;
    logic [SOL_W-1:0]    rr_diff;
    logic [P_W-1:0]      mul_add;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_res     = i_s_tdata[MOD_W-1:0];
    assign in_m       = i_s_tdata[2*MOD_W-1:MOD_W];
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(M_TDATA_W - 2*SOL_W - ST_W){1'b0}}, r_out_st, r_out_mod, r_out_sol};

    always_comb begin
        shift_ok = {r_d, 1'b0} <= {2'b00, r_ra};
        sub_ge   = {1'b0, r_ra} >= r_d;
        am_b     = (r_state == S_MMA) ? r_acc : r_x;
        am_gap   = r_modr - am_b;
        am_res   = (r_acc >= am_gap) ? (r_acc - am_gap) : (r_acc + am_b);
        fix_inv  = (r_ta[SOL_W-1:0] >= r_modr) ? (r_ta[SOL_W-1:0] - r_modr)
                                                 : r_ta[SOL_W-1:0];
        rr_diff  = (r_sol >= r_ra) ? (r_sol - r_ra) : (r_sol + (r_modr - r_ra));
        mul_add  = r_mm[MOD_W-1] ? {{MOD_W{1'b0}}, r_mc} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_RED;
            r_st     <= ST_OK;
            r_sol    <= '0;
            r_modr   <= {{(SOL_W-1){1'b0}}, 1'b1};
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_start <= i_s_tuser;
                        r_res   <= in_res;
                        r_m     <= in_m;
                        if (in_m == '0) begin
                            if (i_s_tuser) begin
                                r_sol  <= '0;
                                r_modr <= {{(SOL_W-1){1'b0}}, 1'b1};
                                r_st   <= ST_NOT_COPRIME;
                            end else if (r_st == ST_OK) begin
                                r_st <= ST_NOT_COPRIME;
                            end
                            r_state <= S_OUT;
                        end else if (!i_s_tuser && r_st != ST_OK) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ra    <= {{(SOL_W-MOD_W){1'b0}}, in_res};
                            r_d     <= {{(SOL_W-MOD_W+1){1'b0}}, in_m};
                            r_td    <= '0;
                            r_cnt   <= '0;
                            r_phase <= PH_RED;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (shift_ok) begin
                        r_d   <= {r_d[SOL_W-1:0], 1'b0};
                        r_td  <= r_td <<< 1;
                        r_cnt <= r_cnt + 6'd1;
                    end else begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (sub_ge) begin
                        r_ra <= r_ra - r_d[SOL_W-1:0];
                        r_ta <= r_ta - r_td;
                    end
                    r_d  <= r_d >> 1;
                    r_td <= r_td >>> 1;
                    if (r_cnt == '0) begin
                        r_state <= S_DDONE;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DDONE: begin
                    unique case (r_phase)
                        PH_RED: begin
                            r_res <= r_ra[MOD_W-1:0];
                            if (r_start) begin
                                r_sol   <= r_ra;
                                r_modr  <= {{(SOL_W-MOD_W){1'b0}}, r_m};
                                r_st    <= ST_OK;
                                r_state <= S_OUT;
                            end else begin
                                r_ra    <= r_modr;
                                r_rb    <= {{(SOL_W-MOD_W){1'b0}}, r_m};
                                r_ta    <= '0;
                                r_tb    <= T_W'(1);
                                r_phase <= PH_EUC;
                                r_state <= S_ECHK;
                            end
                        end
                        PH_EUC: begin
                            r_ra    <= r_rb;
                            r_rb    <= r_ra;
                            r_ta    <= r_tb;
                            r_tb    <= r_ta;
                            r_state <= S_ECHK;
                        end
                        PH_RBIG: begin
                            r_x     <= rr_diff;
                            r_acc   <= '0;
                            r_cnt   <= 6'd63;
                            r_state <= S_MMA;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_ECHK: begin
                    if (r_rb == '0) begin
                        if (r_ra != {{(SOL_W-1){1'b0}}, 1'b1}) begin
                            r_st    <= ST_NOT_COPRIME;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FIX1;
                        end
                    end else begin
                        r_d     <= {1'b0, r_rb};
                        r_td    <= r_tb;
                        r_cnt   <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_FIX1: begin
                    if (r_ta < 0) begin
                        r_ta <= r_ta + $signed({4'b0000, r_modr});
                    end
                    r_state <= S_FIX2;
                end
                S_FIX2: begin
                    r_inv   <= fix_inv;
                    r_macc  <= '0;
                    r_mc    <= r_modr;
                    r_mm    <= r_m;
                    r_cnt   <= 6'(MOD_W - 1);
                    r_phase <= PH_PROD;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_macc <= {r_macc[P_W-2:0], 1'b0} + mul_add;
                    r_mm   <= {r_mm[MOD_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_MCHK;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_MCHK: begin
                    if (r_phase == PH_PROD) begin
                        if (r_macc[P_W-1:SOL_W] != '0) begin
                            r_st    <= ST_OVERFLOW;
                            r_state <= S_OUT;
                        end else begin
                            r_prod  <= r_macc[SOL_W-1:0];
                            r_ra    <= {{(SOL_W-MOD_W){1'b0}}, r_res};
                            r_d     <= {1'b0, r_modr};
                            r_td    <= '0;
                            r_cnt   <= '0;
                            r_phase <= PH_RBIG;
                            r_state <= S_NORM;
                        end
                    end else begin
                        r_sol   <= r_macc[SOL_W-1:0] + {{(SOL_W-MOD_W){1'b0}}, r_res};
                        r_modr  <= r_prod;
                        r_state <= S_OUT;
                    end
                end
                S_MMA: begin
                    r_acc   <= am_res;
                    r_state <= S_MMB;
                end
                S_MMB: begin
                    r_inv <= {r_inv[SOL_W-2:0], 1'b0};
                    if (r_inv[SOL_W-1]) begin
                        r_acc <= am_res;
                    end
                    if (r_cnt == '0) begin
                        r_macc  <= '0;
                        r_mc    <= r_inv[SOL_W-1] ? am_res : r_acc;
                        r_mm    <= r_m;
                        r_cnt   <= 6'(MOD_W - 1);
                        r_phase <= PH_SOL;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt   <= r_cnt - 6'd1;
                        r_state <= S_MMA;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_out_sol <= r_sol;
                        r_out_mod <= r_modr;
                        r_out_st  <= r_st;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_modr != '0)
        else $error("running modulus is zero");

    a_sol_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OK) |-> (r_sol < r_modr))
        else $error("running solution not below running modulus");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_d != '0))
        else $error("divider started with zero divisor");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");
`endif

endmodule

// File: sim/crt_solution_checker.sv
`timescale 1ns / 1ps
// Checker for the incremental CRT solver: watches both stream channels, predicts
// each result word from accepted congruences and compares. Depends on crt_pkg.
module crt_solution_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [crt_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [crt_pkg::M_TDATA_W-1:0]  i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results_seen
);
    import crt_pkg::*;

    typedef struct packed {
        logic [SOL_W-1:0] solution;
        logic [SOL_W-1:0] modulus;
        t_status          status;
    } t_crt_state;

    t_crt_state crt_now;
    t_crt_state expected_q[$];

    function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y, logic [63:0] n);
        logic [63:0] gap;
        gap = n - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function automatic logic [63:0] mod_sub(logic [63:0] x, logic [63:0] y, logic [63:0] n);
        return (x >= y) ? x - y : x + (n - y);
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] n);
        logic [63:0] acc;
        acc = '0;
        for (int b = 63; b >= 0; b--) begin
            acc = mod_add(acc, acc, n);
            if (y[b]) acc = mod_add(acc, x, n);
        end
        return acc;
    endfunction

    function automatic t_crt_state merge_congruence(t_crt_state cur, logic start,
                                                    logic [31:0] res_in, logic [31:0] mod_in);
        t_crt_state nxt;
        logic [63:0] m, r, big, ra, rb, ta, tb, q, rn, tn, diff, k;
        nxt = cur;
        m = {32'd0, mod_in};
        r = {32'd0, res_in};
        if (m != 0) r = r % m;
        if (start) begin
            nxt.solution = '0;
            nxt.modulus  = 64'd1;
            if (m == 0) begin
                nxt.status = ST_NOT_COPRIME;
            end else begin
                nxt.solution = r;
                nxt.modulus  = m;
                nxt.status   = ST_OK;
            end
        end else if (cur.status == ST_OK) begin
            if (m == 0) begin
                nxt.status = ST_NOT_COPRIME;
            end else begin
                big = cur.modulus;
                ra = big; rb = m; ta = '0; tb = 64'd1 % big;
                while (rb != 0) begin
                    q  = ra / rb;
                    rn = ra - q * rb;
                    tn = mod_sub(ta, mod_mul(q % big, tb, big), big);
                    ra = rb; rb = rn; ta = tb; tb = tn;
                end
                if (ra != 64'd1) begin
                    nxt.status = ST_NOT_COPRIME;
                end else if (big > 64'hFFFF_FFFF_FFFF_FFFF / m) begin
                    nxt.status = ST_OVERFLOW;
                end else begin
                    diff = mod_sub(cur.solution % big, r % big, big);
                    k = mod_mul(diff, ta, big);
                    nxt.solution = r + m * k;
                    nxt.modulus  = big * m;
                end
            end
        end
        return nxt;
    endfunction

    always @(posedge i_clk) begin
        t_crt_state got, want;
        if (!i_rst_n) begin
            crt_now <= '{solution: '0, modulus: 64'd1, status: ST_OK};
            expected_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = merge_congruence(crt_now, i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]);
                crt_now <= want;
                expected_q = {expected_q, want};
            end
            if (i_m_tvalid && i_m_tready) begin
                got.solution = i_m_tdata[63:0];
                got.modulus  = i_m_tdata[127:64];
                got.status   = t_status'(i_m_tdata[129:128]);
                o_results_seen <= o_results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.solution !== want.solution) begin
                        $error("solution: expected %0d, actual %0d", want.solution, got.solution);
                    end
                    if (got.modulus !== want.modulus) begin
                        $error("combined_modulus: expected %0d, actual %0d",
                               want.modulus, got.modulus);
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    end
                    if (got !== want) o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= expected_q.size();
        end
    end
endmodule

// File: sim/tb_crt_incremental_solver.sv
`timescale 1ns / 1ps
// Top of the CRT solver testbench: drives congruence words with random gaps and
// stalls, and reports the verdict. Depends on crt_pkg, the DUT and crt_solution_checker.
module tb_crt_incremental_solver;
    import crt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;
    int                    results_seen;
    int                    words_sent;
    int                    drained;
    logic [31:0]           primes[$];

    crt_incremental_solver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    crt_solution_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic start, input logic [31:0] res, input logic [31:0] md);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {md, res};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    function automatic logic [31:0] rand_modulus();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return primes[$urandom_range(0, primes.size() - 1)];
        if (p < 60) return $urandom_range(1, 64);
        if (p < 63) return 32'd0;
        return $urandom();
    endfunction

    initial begin
        int k;
        int n;
        logic [31:0] md;
        logic [31:0] rs;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        words_sent = 0;
        primes = '{32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23,
                   32'd29, 32'd31, 32'd37, 32'd41, 32'd43, 32'd47, 32'd53, 32'd65521,
                   32'd65537, 32'd2147483647, 32'd4294967291, 32'd4294967279,
                   32'd1000003, 32'd999983};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, zero moduli, sticky errors, overflow and wide residues.
        send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 32'd2, 32'd3);
        send_word(1'b0, 32'd3, 32'd5);
        send_word(1'b0, 32'd2, 32'd7);
        send_word(1'b0, 32'd0, 32'd6);
        send_word(1'b0, 32'd1, 32'd11);
        send_word(1'b1, 32'hFFFF_FFFF, 32'd1);
        send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
        send_word(1'b1, 32'd5, 32'd0);
        send_word(1'b0, 32'd1, 32'd3);
        send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_word(1'b0, 32'h8000_0000, 32'hFFFF_FFEF);
        send_word(1'b0, 32'd7, 32'd3);
        send_word(1'b1, 32'd0, 32'hFFFF_FFFF);
        send_word(1'b0, 32'd0, 32'd0);
        send_word(1'b1, 32'd10, 32'd7);
        send_word(1'b0, 32'd4, 32'd1);
        send_word(1'b0, 32'd100, 32'd9);
        send_word(1'b0, 32'd0, 32'd14);
        s_tvalid <= 1'b0;

        // Hold off until every result is back.
        while (pending != 0) @(negedge i_clk);

        // Random systems: mostly well-formed chains, some noise.
        while (words_sent < 1750) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                md = rand_modulus();
                rs = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
                send_word((k == 0) ? 1'b1 : ($urandom_range(0, 29) == 0), rs, md);
            end
        end
        s_tvalid <= 1'b0;

        drained = 0;
        while (pending != 0 && drained < 200000) begin
            @(negedge i_clk);
            drained++;
        end
        repeat (1000) @(negedge i_clk);
        $display("Sent %0d congruence words in short systems; checked %0d result words.",
                 words_sent, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
